### sv/tftp_read_sender_control_assert.svh
// ----------------------------------------------------------------------------
// tftp_read_sender_control_assert.svh
// Assertion macros for the TFTP read sender control block.
// ----------------------------------------------------------------------------
`ifndef TFTP_READ_SENDER_CONTROL_ASSERT_SVH
`define TFTP_READ_SENDER_CONTROL_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define TRSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define TRSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define TRSC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TRSC_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

### sv/trsc_pkg.sv
// ----------------------------------------------------------------------------
// trsc_pkg
// Types and constants shared by the TFTP read sender control block.
// ----------------------------------------------------------------------------
package trsc_pkg;

  localparam int unsigned KindW   = 2;
  localparam int unsigned PlenW   = 16;
  localparam int unsigned OpW     = 16;
  localparam int unsigned BlkW    = 16;
  localparam int unsigned ChunkW  = 10;
  localparam int unsigned ActW    = 3;
  localparam int unsigned RetryW  = 5;
  localparam int unsigned CfgW    = 4;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 3;

  localparam int unsigned BlockSize = 512;

  localparam logic [OpW-1:0]   OpAck        = 16'd4;
  localparam logic [OpW-1:0]   OpError      = 16'd5;
  localparam logic [PlenW-1:0] MinPacketLen = 16'd4;
  localparam logic [CfgW-1:0]  MaxRetriesRst = 4'd3;

  // register word index (paddr[2])
  localparam logic RegMaxRetries = 1'b0;

  typedef enum logic [KindW-1:0] {
    KindStart   = 2'd0,
    KindPacket  = 2'd1,
    KindTimeout = 2'd2
  } kind_e;

  typedef enum logic [ActW-1:0] {
    ActNone    = 3'd0,
    ActSend    = 3'd1,
    ActResend  = 3'd2,
    ActDone    = 3'd3,
    ActTimeout = 3'd4,
    ActPeerErr = 3'd5,
    ActBadOp   = 3'd6,
    ActReadErr = 3'd7
  } action_e;

endpackage

### sv/trsc_if.sv
// ----------------------------------------------------------------------------
// trsc_if
// Valid/ready channels for protocol events in and sender actions out.
// ----------------------------------------------------------------------------
interface trsc_in_if;
  logic                         valid;
  logic                         ready;
  logic [trsc_pkg::KindW-1:0]   kind;
  logic [trsc_pkg::PlenW-1:0]   packet_length;
  logic [trsc_pkg::OpW-1:0]     opcode;
  logic [trsc_pkg::BlkW-1:0]    ack_block;
  logic [trsc_pkg::ChunkW-1:0]  chunk_length;
  logic                         read_error;

  modport source (
    output valid, kind, packet_length, opcode, ack_block, chunk_length, read_error,
    input  ready
  );
  modport sink (
    input  valid, kind, packet_length, opcode, ack_block, chunk_length, read_error,
    output ready
  );
endinterface

interface trsc_out_if;
  logic                         valid;
  logic                         ready;
  logic [trsc_pkg::ActW-1:0]    action;
  logic [trsc_pkg::BlkW-1:0]    block_number;
  logic [trsc_pkg::ChunkW-1:0]  data_length;
  logic                         active;

  modport source (
    output valid, action, block_number, data_length, active,
    input  ready
  );
  modport sink (
    input  valid, action, block_number, data_length, active,
    output ready
  );
endinterface

### sv/tftp_read_sender_control.sv
// ----------------------------------------------------------------------------
// tftp_read_sender_control
// Lock-step TFTP read sender: decides send / resend / done / abort per event.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one protocol event per transaction: start, received packet
//   (length, opcode, ACK block) or receive timeout, plus the next file chunk
//   length and its read status. out_o returns exactly one action per event,
//   with the block number and payload length of any DATA packet to transmit
//   and whether a transfer is still running.
//   The event is captured in an input register and decided by the state
//   logic on its way into the output register; out_o.valid rises when the
//   event moves from the input register into the output register. One
//   event is accepted every cycle while out_o is drained. The sender state
//   advances when the event moves into the output register, so
//   back-to-back events see each other's updates.
//   When out_o stalls, the output register holds and the input register
//   fills; in_i.ready drops only when both are occupied.
//   Reset leaves the block idle (no transfer, next block 1) with
//   max_retries = 3, written and read over APB at byte address 0; the user
//   must write it only while no event is in flight; the block does not check.
// ----------------------------------------------------------------------------
module tftp_read_sender_control #(
  parameter int unsigned BLOCK_SIZE = trsc_pkg::BlockSize
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  trsc_in_if.sink                         in_i,
  trsc_out_if.source                      out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [trsc_pkg::ApbAddrW-1:0]   paddr,
  input  logic [trsc_pkg::ApbDataW-1:0]   pwdata,
  output logic [trsc_pkg::ApbDataW-1:0]   prdata,
  output logic                            pready
);

  localparam logic [trsc_pkg::ChunkW-1:0] BlkSizeLen = trsc_pkg::ChunkW'(BLOCK_SIZE);

  // configuration
  logic [trsc_pkg::CfgW-1:0] max_retries_q;
  logic                      cfg_wr;

  // input register
  logic                         in_valid_q;
  logic [trsc_pkg::KindW-1:0]   kind_q;
  logic [trsc_pkg::PlenW-1:0]   plen_q;
  logic [trsc_pkg::OpW-1:0]     opcode_q;
  logic [trsc_pkg::BlkW-1:0]    ack_q;
  logic [trsc_pkg::ChunkW-1:0]  chunk_q;
  logic                         rerr_q;

  // sender state
  logic                         in_transfer_q, in_transfer_d;
  logic [trsc_pkg::BlkW-1:0]    next_block_q, next_block_d;
  logic                         awaiting_final_q, awaiting_final_d;
  logic [trsc_pkg::BlkW-1:0]    final_block_q, final_block_d;
  logic [trsc_pkg::RetryW-1:0]  retry_count_q, retry_count_d;
  logic [trsc_pkg::ChunkW-1:0]  last_length_q, last_length_d;

  // output register
  logic                         out_valid_q;
  trsc_pkg::action_e            action_q, action_d;
  logic [trsc_pkg::BlkW-1:0]    block_q, block_d;
  logic [trsc_pkg::ChunkW-1:0]  len_q, len_d;
  logic                         active_q;

  // handshake
  logic out_free;
  logic adv;

  // decode helpers
  logic [trsc_pkg::BlkW-1:0]    last_blk;
  logic [trsc_pkg::BlkW-1:0]    send_base;
  logic [trsc_pkg::ChunkW-1:0]  chunk_clamped;
  logic                         chunk_short;

  // --------------------------------------------------------------------------
  // APB configuration
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == trsc_pkg::RegMaxRetries);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_retries_q <= trsc_pkg::MaxRetriesRst;
    end else if (cfg_wr) begin
      max_retries_q <= pwdata[trsc_pkg::CfgW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == trsc_pkg::RegMaxRetries) begin
      prdata = {{(trsc_pkg::ApbDataW - trsc_pkg::CfgW){1'b0}}, max_retries_q};
    end
  end

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  assign out_free   = !out_valid_q || out_o.ready;
  assign adv        = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      kind_q   <= in_i.kind;
      plen_q   <= in_i.packet_length;
      opcode_q <= in_i.opcode;
      ack_q    <= in_i.ack_block;
      chunk_q  <= in_i.chunk_length;
      rerr_q   <= in_i.read_error;
    end
  end

  // --------------------------------------------------------------------------
  // Decision logic
  // --------------------------------------------------------------------------
  assign last_blk      = next_block_q - trsc_pkg::BlkW'(1);
  assign send_base     = (kind_q == trsc_pkg::KindStart) ? trsc_pkg::BlkW'(1) : next_block_q;
  assign chunk_clamped = (chunk_q > BlkSizeLen) ? BlkSizeLen : chunk_q;
  assign chunk_short   = chunk_clamped < BlkSizeLen;

  always_comb begin
    in_transfer_d    = in_transfer_q;
    next_block_d     = next_block_q;
    awaiting_final_d = awaiting_final_q;
    final_block_d    = final_block_q;
    retry_count_d    = retry_count_q;
    last_length_d    = last_length_q;
    action_d         = trsc_pkg::ActNone;
    block_d          = '0;
    len_d            = '0;

    unique case (kind_q)
      trsc_pkg::KindStart: begin
        // a start always drops whatever transfer was running
        awaiting_final_d = 1'b0;
        final_block_d    = '0;
        retry_count_d    = '0;
        last_length_d    = '0;
        next_block_d     = trsc_pkg::BlkW'(1);
        if (rerr_q) begin
          in_transfer_d = 1'b0;
          action_d      = trsc_pkg::ActReadErr;
        end else begin
          in_transfer_d = 1'b1;
          action_d      = trsc_pkg::ActSend;
          block_d       = send_base;
          len_d         = chunk_clamped;
          last_length_d = chunk_clamped;
          if (chunk_short) begin
            awaiting_final_d = 1'b1;
            final_block_d    = send_base;
          end
          next_block_d = send_base + trsc_pkg::BlkW'(1);
        end
      end
      trsc_pkg::KindPacket: begin
        if (in_transfer_q && (plen_q >= trsc_pkg::MinPacketLen)) begin
          retry_count_d = '0;
          priority if (opcode_q == trsc_pkg::OpAck) begin
            priority if (awaiting_final_q && (ack_q == final_block_q)) begin
              action_d      = trsc_pkg::ActDone;
              in_transfer_d = 1'b0;
            end else if ((ack_q == last_blk) && !awaiting_final_q) begin
              if (rerr_q) begin
                action_d      = trsc_pkg::ActReadErr;
                in_transfer_d = 1'b0;
              end else begin
                action_d      = trsc_pkg::ActSend;
                block_d       = send_base;
                len_d         = chunk_clamped;
                last_length_d = chunk_clamped;
                if (chunk_short) begin
                  awaiting_final_d = 1'b1;
                  final_block_d    = send_base;
                end
                next_block_d = send_base + trsc_pkg::BlkW'(1);
              end
            end else if (ack_q <= last_blk) begin
              action_d = trsc_pkg::ActResend;
              block_d  = last_blk;
              len_d    = last_length_q;
            end else begin
              // ACK ahead of anything sent: ignored
              action_d = trsc_pkg::ActNone;
            end
          end else if (opcode_q == trsc_pkg::OpError) begin
            action_d      = trsc_pkg::ActPeerErr;
            in_transfer_d = 1'b0;
          end else begin
            action_d      = trsc_pkg::ActBadOp;
            in_transfer_d = 1'b0;
          end
        end
      end
      trsc_pkg::KindTimeout: begin
        if (in_transfer_q) begin
          if (retry_count_q <= {1'b0, max_retries_q}) begin
            retry_count_d = retry_count_q + trsc_pkg::RetryW'(1);
            action_d      = trsc_pkg::ActResend;
            block_d       = last_blk;
            len_d         = last_length_q;
          end else begin
            action_d      = trsc_pkg::ActTimeout;
            in_transfer_d = 1'b0;
          end
        end
      end
      default: begin
        action_d = trsc_pkg::ActNone;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // State and output registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_transfer_q    <= 1'b0;
      next_block_q     <= trsc_pkg::BlkW'(1);
      awaiting_final_q <= 1'b0;
      final_block_q    <= '0;
      retry_count_q    <= '0;
      last_length_q    <= '0;
    end else if (adv) begin
      in_transfer_q    <= in_transfer_d;
      next_block_q     <= next_block_d;
      awaiting_final_q <= awaiting_final_d;
      final_block_q    <= final_block_d;
      retry_count_q    <= retry_count_d;
      last_length_q    <= last_length_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      action_q <= action_d;
      block_q  <= block_d;
      len_q    <= len_d;
      active_q <= in_transfer_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.action       = action_q;
  assign out_o.block_number = block_q;
  assign out_o.data_length  = len_q;
  assign out_o.active       = active_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `include "tftp_read_sender_control_assert.svh"

  // reported activity matches the state left behind by the same event
  `TRSC_ASSERT_NXT(a_active_tracks_state, clk_i, rst_ni, adv, out_o.active == in_transfer_q)

  // a new block always advances the block counter past it
  `TRSC_ASSERT_NXT(a_send_bumps_block, clk_i, rst_ni, adv && (action_d == trsc_pkg::ActSend),
    next_block_q == (out_o.block_number + trsc_pkg::BlkW'(1)))

  // a short block arms the end-of-transfer check on that block
  `TRSC_ASSERT_NXT(a_short_marks_final, clk_i, rst_ni,
    adv && (action_d == trsc_pkg::ActSend) && (len_d < BlkSizeLen),
    awaiting_final_q && (final_block_q == out_o.block_number))

  // only send and resend carry a data packet description
  `TRSC_ASSERT_IMP(a_no_payload_otherwise, clk_i, rst_ni,
    out_o.valid && (out_o.action != trsc_pkg::ActSend) && (out_o.action != trsc_pkg::ActResend),
    (out_o.block_number == '0) && (out_o.data_length == '0))

  // a decided event only leaves the block active through send or resend or ignore
  `TRSC_ASSERT_IMP(a_abort_clears_active, clk_i, rst_ni,
    out_o.valid && (out_o.action != trsc_pkg::ActSend) && (out_o.action != trsc_pkg::ActResend)
      && (out_o.action != trsc_pkg::ActNone),
    !out_o.active)

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the TFTP read sender control. A behavioural model
// of the sender state predicts one action per accepted event. A checker
// compares each returned action field by field. Test tasks cover the
// max_retries register, directed protocol corners, output backpressure and
// random lock-step transfers under several retry limits.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned MaxPrinted  = 50;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned PhaseEvents = 250;

  localparam logic [trsc_pkg::KindW-1:0]    KindUnused = 2'd3;
  localparam logic [trsc_pkg::ChunkW-1:0]   FullBlock  = trsc_pkg::ChunkW'(trsc_pkg::BlockSize);
  localparam logic [trsc_pkg::ApbAddrW-1:0] MaxRetriesAddr = {trsc_pkg::RegMaxRetries, 2'b00};

  typedef struct {
    logic [trsc_pkg::KindW-1:0]  kind;
    logic [trsc_pkg::PlenW-1:0]  plen;
    logic [trsc_pkg::OpW-1:0]    opcode;
    logic [trsc_pkg::BlkW-1:0]   ack;
    logic [trsc_pkg::ChunkW-1:0] chunk;
    logic                        rerr;
  } tftp_event_t;

  typedef struct {
    trsc_pkg::action_e           action;
    logic [trsc_pkg::BlkW-1:0]   blk;
    logic [trsc_pkg::ChunkW-1:0] len;
    logic                        active;
  } sender_action_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [trsc_pkg::ApbAddrW-1:0] paddr;
  logic [trsc_pkg::ApbDataW-1:0] pwdata;
  logic [trsc_pkg::ApbDataW-1:0] prdata;
  logic                          pready;

  trsc_in_if  ev_if ();
  trsc_out_if act_if ();

  tftp_read_sender_control u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (ev_if),
    .out_o   (act_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // sender state model
  logic [trsc_pkg::CfgW-1:0]   cfg_max_retries    = trsc_pkg::MaxRetriesRst;
  logic                        snd_in_transfer    = 1'b0;
  logic [trsc_pkg::BlkW-1:0]   snd_next_block     = 16'd1;
  logic                        snd_awaiting_final = 1'b0;
  logic [trsc_pkg::BlkW-1:0]   snd_final_block    = '0;
  logic [trsc_pkg::RetryW-1:0] snd_retries        = '0;
  logic [trsc_pkg::ChunkW-1:0] snd_last_len       = '0;

  sender_action_t pending_actions[$];
  int unsigned    mismatch_count;
  int unsigned    acted_events;
  int unsigned    cycle_count;
  bit             src_idle_en;
  bit             sink_idle_en;
  int unsigned    hold_seq;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatch_count < MaxPrinted) begin
      $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------- model
  function automatic void issue_block(input logic [trsc_pkg::ChunkW-1:0] chunk,
                                      inout sender_action_t res);
    logic [trsc_pkg::ChunkW-1:0] n;
    n = (chunk > FullBlock) ? FullBlock : chunk;
    res.action   = trsc_pkg::ActSend;
    res.blk      = snd_next_block;
    res.len      = n;
    snd_last_len = n;
    if (n < FullBlock) begin
      snd_awaiting_final = 1'b1;
      snd_final_block    = snd_next_block;
    end
    snd_next_block = snd_next_block + 1'b1;
  endfunction

  function automatic void resend_last(inout sender_action_t res);
    res.action = trsc_pkg::ActResend;
    res.blk    = snd_next_block - 1'b1;
    res.len    = snd_last_len;
  endfunction

  function automatic sender_action_t predict_action(input tftp_event_t ev);
    sender_action_t            res;
    logic [trsc_pkg::BlkW-1:0] last_sent;
    res       = '{action: trsc_pkg::ActNone, blk: '0, len: '0, active: 1'b0};
    last_sent = snd_next_block - 1'b1;
    if (ev.kind == trsc_pkg::KindStart) begin
      snd_in_transfer    = 1'b0;
      snd_awaiting_final = 1'b0;
      snd_final_block    = '0;
      snd_retries        = '0;
      snd_next_block     = 16'd1;
      snd_last_len       = '0;
      if (ev.rerr) begin
        res.action = trsc_pkg::ActReadErr;
      end else begin
        snd_in_transfer = 1'b1;
        issue_block(ev.chunk, res);
      end
    end else if (ev.kind == trsc_pkg::KindPacket && snd_in_transfer &&
                 ev.plen >= trsc_pkg::MinPacketLen) begin
      snd_retries = '0;
      if (ev.opcode == trsc_pkg::OpAck) begin
        if (snd_awaiting_final && ev.ack == snd_final_block) begin
          res.action      = trsc_pkg::ActDone;
          snd_in_transfer = 1'b0;
        end else if (ev.ack == last_sent && !snd_awaiting_final) begin
          if (ev.rerr) begin
            res.action      = trsc_pkg::ActReadErr;
            snd_in_transfer = 1'b0;
          end else begin
            issue_block(ev.chunk, res);
          end
        end else if (ev.ack <= last_sent) begin
          resend_last(res);
        end
        // ACK newer than the last sent block: ignored
      end else if (ev.opcode == trsc_pkg::OpError) begin
        res.action      = trsc_pkg::ActPeerErr;
        snd_in_transfer = 1'b0;
      end else begin
        res.action      = trsc_pkg::ActBadOp;
        snd_in_transfer = 1'b0;
      end
    end else if (ev.kind == trsc_pkg::KindTimeout && snd_in_transfer) begin
      if (snd_retries <= trsc_pkg::RetryW'(cfg_max_retries)) begin
        snd_retries = snd_retries + 1'b1;
        resend_last(res);
      end else begin
        res.action      = trsc_pkg::ActTimeout;
        snd_in_transfer = 1'b0;
      end
    end
    res.active = snd_in_transfer;
    return res;
  endfunction

  // -------------------------------------------------------------- stimulus
  function automatic tftp_event_t make_event(input logic [trsc_pkg::KindW-1:0] kind,
                                             input logic [trsc_pkg::PlenW-1:0] plen,
                                             input logic [trsc_pkg::OpW-1:0] opcode,
                                             input logic [trsc_pkg::BlkW-1:0] ack,
                                             input logic [trsc_pkg::ChunkW-1:0] chunk,
                                             input logic rerr);
    tftp_event_t e;
    e.kind   = kind;
    e.plen   = plen;
    e.opcode = opcode;
    e.ack    = ack;
    e.chunk  = chunk;
    e.rerr   = rerr;
    return e;
  endfunction

  function automatic int unsigned idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic [trsc_pkg::ChunkW-1:0] random_chunk();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return FullBlock;
    if (pick < 85) return trsc_pkg::ChunkW'($urandom_range(0, 511));
    return trsc_pkg::ChunkW'($urandom_range(513, 1023));
  endfunction

  // Mostly well-formed lock-step traffic around the block last sent, with
  // retries, stale and future ACKs, aborts and junk mixed in.
  function automatic tftp_event_t random_event();
    tftp_event_t               e;
    int unsigned               pick;
    logic [trsc_pkg::BlkW-1:0] last_sent;
    last_sent = snd_next_block - 1'b1;
    e = make_event(trsc_pkg::KindPacket, trsc_pkg::PlenW'($urandom_range(4, 65535)),
                   trsc_pkg::OpAck, last_sent, random_chunk(), $urandom_range(0, 39) == 0);
    pick = $urandom_range(0, 99);
    if (!snd_in_transfer) begin
      if (pick < 80) begin
        e.kind = trsc_pkg::KindStart;
      end else if (pick < 88) begin
        e.kind = trsc_pkg::KindTimeout;
      end else if (pick < 94) begin
        e.kind = KindUnused;
      end else begin
        e.ack    = trsc_pkg::BlkW'($urandom());
        e.opcode = trsc_pkg::OpW'($urandom());
      end
    end else if (pick < 55) begin
      // ACK of the block in flight
    end else if (pick < 65) begin
      e.ack = trsc_pkg::BlkW'($urandom_range(0, last_sent));
    end else if (pick < 70) begin
      if (last_sent != 16'hFFFF) e.ack = trsc_pkg::BlkW'($urandom_range(last_sent + 1, 65535));
      else e.ack = trsc_pkg::BlkW'($urandom());
    end else if (pick < 82) begin
      e.kind = trsc_pkg::KindTimeout;
    end else if (pick < 86) begin
      e.opcode = trsc_pkg::OpError;
    end else if (pick < 90) begin
      e.opcode = trsc_pkg::OpW'($urandom());
    end else if (pick < 95) begin
      e.plen   = trsc_pkg::PlenW'($urandom_range(0, 3));
      e.opcode = trsc_pkg::OpW'($urandom());
    end else if (pick < 98) begin
      e.kind = trsc_pkg::KindStart;
    end else begin
      e.kind = KindUnused;
    end
    return e;
  endfunction

  task automatic send_event(input tftp_event_t e);
    int unsigned    gap;
    sender_action_t want;
    gap = (src_idle_en && $urandom_range(0, 3) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      ev_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    ev_if.valid         <= 1'b1;
    ev_if.kind          <= e.kind;
    ev_if.packet_length <= e.plen;
    ev_if.opcode        <= e.opcode;
    ev_if.ack_block     <= e.ack;
    ev_if.chunk_length  <= e.chunk;
    ev_if.read_error    <= e.rerr;
    @(posedge clk_i);
    while (!ev_if.ready) @(posedge clk_i);
    want = predict_action(e);
    if (want.action != trsc_pkg::ActNone) acted_events++;
    pending_actions.push_back(want);
  endtask

  task automatic wait_idle();
    ev_if.valid <= 1'b0;
    while (pending_actions.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic is_write, input logic [trsc_pkg::ApbAddrW-1:0] addr,
                            input logic [trsc_pkg::ApbDataW-1:0] wdata,
                            output logic [trsc_pkg::ApbDataW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_max_retries(input logic [trsc_pkg::CfgW-1:0] value);
    logic [trsc_pkg::ApbDataW-1:0] rd;
    wait_idle();
    apb_access(1'b1, MaxRetriesAddr, trsc_pkg::ApbDataW'(value), rd);
    cfg_max_retries = value;
    apb_access(1'b0, MaxRetriesAddr, '0, rd);
    if (rd[trsc_pkg::CfgW-1:0] !== value)
      report_mismatch("max_retries readback", rd[trsc_pkg::CfgW-1:0], value);
  endtask

  // --------------------------------------------------------------- checker
  always @(posedge clk_i) begin : action_check
    sender_action_t want;
    if (rst_ni && act_if.valid === 1'b1 && act_if.ready) begin
      if (pending_actions.size() == 0) begin
        report_mismatch("action with no transaction pending", act_if.action,
                        trsc_pkg::ActNone);
      end else begin
        want = pending_actions.pop_front();
        if (act_if.action !== want.action)
          report_mismatch("action", act_if.action, want.action);
        if (act_if.block_number !== want.blk)
          report_mismatch("block_number", act_if.block_number, want.blk);
        if (act_if.data_length !== want.len)
          report_mismatch("data_length", act_if.data_length, want.len);
        if (act_if.active !== want.active)
          report_mismatch("active", act_if.active, want.active);
      end
    end
  end

  // Output side: random stalls, plus a long hold-off whenever hold_seq moves.
  initial begin : sink_ctrl
    int unsigned seen_seq;
    int unsigned hold_left;
    int unsigned stall_left;
    seen_seq   = 0;
    hold_left  = 0;
    stall_left = 0;
    act_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seq != seen_seq) begin
        seen_seq  = hold_seq;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        act_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        act_if.ready <= 1'b0;
      end else begin
        act_if.ready <= 1'b1;
        if (sink_idle_en && $urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  // ------------------------------------------------------------------ tests
  task automatic test_registers();
    logic [trsc_pkg::ApbDataW-1:0] rd;
    apb_access(1'b0, MaxRetriesAddr, '0, rd);
    if (rd[trsc_pkg::CfgW-1:0] !== trsc_pkg::MaxRetriesRst)
      report_mismatch("max_retries after reset", rd[trsc_pkg::CfgW-1:0],
                      trsc_pkg::MaxRetriesRst);
    set_max_retries(4'd15);
    set_max_retries(4'd0);
  endtask

  task automatic test_directed();
    set_max_retries(4'd1);
    // idle: everything but a start is ignored
    send_event(make_event(trsc_pkg::KindPacket, 16'd4, trsc_pkg::OpAck, 16'd0, FullBlock, 1'b0));
    send_event(make_event(trsc_pkg::KindTimeout, 16'd0, 16'd0, 16'd0, 10'd0, 1'b0));
    send_event(make_event(KindUnused, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'h3FF, 1'b1));
    send_event(make_event(trsc_pkg::KindStart, 16'd0, 16'd0, 16'd0, FullBlock, 1'b1));
    // oversized chunk saturates to a full block
    send_event(make_event(trsc_pkg::KindStart, 16'd0, 16'd0, 16'd0, 10'h3FF, 1'b0));
    send_event(make_event(trsc_pkg::KindPacket, 16'hFFFF, trsc_pkg::OpAck, 16'd1, FullBlock,
                          1'b0));
    send_event(make_event(trsc_pkg::KindPacket, 16'd4, trsc_pkg::OpAck, 16'd0, FullBlock, 1'b0));
    send_event(make_event(trsc_pkg::KindPacket, 16'd4, trsc_pkg::OpAck, 16'hFFFF, FullBlock,
                          1'b0));
    // runt packet: ignored, no abort, retry count kept
    send_event(make_event(trsc_pkg::KindPacket, 16'd3, trsc_pkg::OpError, 16'd2, FullBlock,
                          1'b0));
    send_event(make_event(trsc_pkg::KindTimeout, 16'd0, 16'd0, 16'd0, 10'd0, 1'b0));
    send_event(make_event(trsc_pkg::KindTimeout, 16'd0, 16'd0, 16'd0, 10'd0, 1'b0));
    // empty final block, stale ACK, then retries run out
    send_event(make_event(trsc_pkg::KindPacket, 16'd4, trsc_pkg::OpAck, 16'd2, 10'd0, 1'b0));
    send_event(make_event(trsc_pkg::KindPacket, 16'd4, trsc_pkg::OpAck, 16'd2, FullBlock, 1'b0));
    send_event(make_event(trsc_pkg::KindTimeout, 16'd0, 16'd0, 16'd0, 10'd0, 1'b0));
    send_event(make_event(trsc_pkg::KindTimeout, 16'd0, 16'd0, 16'd0, 10'd0, 1'b0));
    send_event(make_event(trsc_pkg::KindTimeout, 16'd0, 16'd0, 16'd0, 10'd0, 1'b0));
    // single short block completes
    send_event(make_event(trsc_pkg::KindStart, 16'd0, 16'd0, 16'd0, 10'd100, 1'b0));
    send_event(make_event(trsc_pkg::KindPacket, 16'd4, trsc_pkg::OpAck, 16'd1, 10'd0, 1'b0));
    // restart while active, then the abort paths
    send_event(make_event(trsc_pkg::KindStart, 16'd0, 16'd0, 16'd0, FullBlock, 1'b0));
    send_event(make_event(trsc_pkg::KindStart, 16'd0, 16'd0, 16'd0, 10'd511, 1'b0));
    send_event(make_event(trsc_pkg::KindPacket, 16'd4, trsc_pkg::OpError, 16'd0, FullBlock,
                          1'b0));
    send_event(make_event(trsc_pkg::KindStart, 16'd0, 16'd0, 16'd0, FullBlock, 1'b0));
    send_event(make_event(trsc_pkg::KindPacket, 16'd4, 16'hFFFF, 16'd1, FullBlock, 1'b0));
    send_event(make_event(trsc_pkg::KindStart, 16'd0, 16'd0, 16'd0, FullBlock, 1'b0));
    send_event(make_event(trsc_pkg::KindPacket, 16'd4, trsc_pkg::OpAck, 16'd1, FullBlock, 1'b1));
    wait_idle();
  endtask

  // Output held off while events keep coming: both stages fill, input stalls.
  task automatic test_backpressure();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    hold_seq++;
    send_event(make_event(trsc_pkg::KindStart, 16'd0, 16'd0, 16'd0, FullBlock, 1'b0));
    repeat (40) send_event(random_event());
    wait_idle();
  endtask

  task automatic test_random();
    logic [trsc_pkg::CfgW-1:0] phase_retries[5];
    int unsigned               start_count;
    phase_retries[0] = 4'd0;
    phase_retries[1] = 4'd15;
    phase_retries[2] = trsc_pkg::MaxRetriesRst;
    phase_retries[3] = trsc_pkg::CfgW'($urandom_range(0, 15));
    phase_retries[4] = trsc_pkg::CfgW'($urandom_range(0, 15));
    for (int p = 0; p < 5; p++) begin
      set_max_retries(phase_retries[p]);
      src_idle_en  = (p != 0);
      sink_idle_en = (p != 0 && p != 2);
      start_count  = acted_events;
      while (acted_events - start_count < PhaseEvents) send_event(random_event());
    end
    wait_idle();
  endtask

  initial begin
    rst_ni              <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    ev_if.valid         <= 1'b0;
    ev_if.kind          <= '0;
    ev_if.packet_length <= '0;
    ev_if.opcode        <= '0;
    ev_if.ack_block     <= '0;
    ev_if.chunk_length  <= '0;
    ev_if.read_error    <= 1'b0;
    src_idle_en    = 1'b1;
    sink_idle_en   = 1'b1;
    hold_seq       = 0;
    mismatch_count = 0;
    acted_events   = 0;
    cycle_count    = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_registers();
    test_directed();
    test_backpressure();
    test_random();

    wait_idle();
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
